// ----- hdl/rssa_pkg.sv -----
// rssa_pkg: shared types, constants and the microcode table of the
// rotated sorted array search unit; no dependencies
package rssa_pkg;

   localparam int DATA_W = 32;   // element and key width
   localparam int POS_W  = 10;   // position field width
   localparam int CNT_W  = 11;   // used_count register width
   localparam int IDX_W  = 10;   // found_index field width
   localparam int UPC_W  = 4;    // microprogram counter width

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef logic [UPC_W-1:0] upc_type;

   // microprogram step addresses
   localparam upc_type UPC_PV0  = 4'd0;
   localparam upc_type UPC_PV1  = 4'd1;
   localparam upc_type UPC_PV2  = 4'd2;
   localparam upc_type UPC_PV3  = 4'd3;
   localparam upc_type UPC_PV4  = 4'd4;
   localparam upc_type UPC_PV5  = 4'd5;
   localparam upc_type UPC_HP0  = 4'd6;
   localparam upc_type UPC_HP1  = 4'd7;
   localparam upc_type UPC_HP2  = 4'd8;
   localparam upc_type UPC_BIN0 = 4'd9;
   localparam upc_type UPC_BIN1 = 4'd10;
   localparam upc_type UPC_BIN2 = 4'd11;
   localparam upc_type UPC_DONE = 4'd12;

   typedef enum logic [2:0] {
      ADDR_NONE,
      ADDR_MID_CALC,
      ADDR_MID_P1,
      ADDR_MID_M1,
      ADDR_LO,
      ADDR_PIV,
      ADDR_ZERO
   } addr_sel_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_HI_LT_LO,
      COND_HI_EQ_LO,
      COND_SUCC_DROP,
      COND_PRED_RISE,
      COND_FIRST_GE_MID,
      COND_KEY_EQ,
      COND_KEY_LE_OR_GT
   } cond_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_SET_MID,
      ACT_LATCH_EM,
      ACT_PIV_MID,
      ACT_PIV_MID_M1,
      ACT_PIV_LO,
      ACT_HI_MID_M1,
      ACT_LO_MID_P1,
      ACT_RANGE_FULL,
      ACT_RANGE_LEFT,
      ACT_RANGE_RIGHT,
      ACT_FOUND_PIV,
      ACT_FOUND_MID,
      ACT_MISS
   } act_type;

   // condition select for the two element compares that reuse one code
   typedef enum logic {
      CMP_FIRST_LE_KEY,
      CMP_KEY_GT
   } cmp_sel_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      cond_type     cond;
      cmp_sel_type  cmp_sel;
      act_type      act_t;
      upc_type      tgt_t;
      act_type      act_f;
      upc_type      tgt_f;
      logic         last;
   } ucode_word_type;

   typedef struct packed {
      logic         start;
      logic         step_en;
      logic         busy;
      logic         finish;
      addr_sel_type addr_sel;
      cond_type     cond;
      cmp_sel_type  cmp_sel;
      act_type      act_t;
      act_type      act_f;
   } seq_ctrl_type;

   // microprogram: pivot bisection, pivot check, binary search, result
   function automatic ucode_word_type ucode_rom(input upc_type addr);
      ucode_word_type w;
      case (addr)
         UPC_PV0:  w = '{ADDR_NONE, COND_HI_LT_LO, CMP_KEY_GT,
                         ACT_RANGE_FULL, UPC_BIN0, ACT_NONE, UPC_PV1, 1'b0};
         UPC_PV1:  w = '{ADDR_MID_CALC, COND_HI_EQ_LO, CMP_KEY_GT,
                         ACT_PIV_LO, UPC_HP0, ACT_SET_MID, UPC_PV2, 1'b0};
         UPC_PV2:  w = '{ADDR_MID_P1, COND_NEVER, CMP_KEY_GT,
                         ACT_NONE, UPC_PV3, ACT_LATCH_EM, UPC_PV3, 1'b0};
         UPC_PV3:  w = '{ADDR_MID_M1, COND_SUCC_DROP, CMP_KEY_GT,
                         ACT_PIV_MID, UPC_HP0, ACT_NONE, UPC_PV4, 1'b0};
         UPC_PV4:  w = '{ADDR_LO, COND_PRED_RISE, CMP_KEY_GT,
                         ACT_PIV_MID_M1, UPC_HP0, ACT_NONE, UPC_PV5, 1'b0};
         UPC_PV5:  w = '{ADDR_NONE, COND_FIRST_GE_MID, CMP_KEY_GT,
                         ACT_HI_MID_M1, UPC_PV0, ACT_LO_MID_P1, UPC_PV0, 1'b0};
         UPC_HP0:  w = '{ADDR_PIV, COND_NEVER, CMP_KEY_GT,
                         ACT_NONE, UPC_HP1, ACT_NONE, UPC_HP1, 1'b0};
         UPC_HP1:  w = '{ADDR_ZERO, COND_KEY_EQ, CMP_KEY_GT,
                         ACT_FOUND_PIV, UPC_DONE, ACT_NONE, UPC_HP2, 1'b0};
         UPC_HP2:  w = '{ADDR_NONE, COND_KEY_LE_OR_GT, CMP_FIRST_LE_KEY,
                         ACT_RANGE_LEFT, UPC_BIN0, ACT_RANGE_RIGHT, UPC_BIN0, 1'b0};
         UPC_BIN0: w = '{ADDR_MID_CALC, COND_HI_LT_LO, CMP_KEY_GT,
                         ACT_MISS, UPC_DONE, ACT_SET_MID, UPC_BIN1, 1'b0};
         UPC_BIN1: w = '{ADDR_NONE, COND_KEY_EQ, CMP_KEY_GT,
                         ACT_FOUND_MID, UPC_DONE, ACT_NONE, UPC_BIN2, 1'b0};
         UPC_BIN2: w = '{ADDR_NONE, COND_KEY_LE_OR_GT, CMP_KEY_GT,
                         ACT_LO_MID_P1, UPC_BIN0, ACT_HI_MID_M1, UPC_BIN0, 1'b0};
         UPC_DONE: w = '{ADDR_NONE, COND_NEVER, CMP_KEY_GT,
                         ACT_NONE, UPC_DONE, ACT_NONE, UPC_DONE, 1'b1};
         default:  w = '{ADDR_NONE, COND_NEVER, CMP_KEY_GT,
                         ACT_MISS, UPC_DONE, ACT_MISS, UPC_DONE, 1'b0};
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/rssa_ram.sv -----
// rssa_ram: generic single-port-write, single-port-read ram with
// registered read data; no dependencies
module rssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/rssa_useq.sv -----
// rssa_useq: microprogram counter, control store and run/idle control
// depends on rssa_pkg
module rssa_useq
   import rssa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         search_go,
   input  logic         cond_true,
   input  logic         rsp_free,
   output seq_ctrl_type ctrl
);

   seq_state_type  state_ff, state_in;
   upc_type        upc_ff, upc_in;
   ucode_word_type word;

   assign word = ucode_rom(upc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (search_go) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (word.last && rsp_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // step counter
   always_comb begin
      upc_in = upc_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (search_go) begin
               upc_in = UPC_PV0;
            end
         end
         SEQ_RUN: begin
            if (!word.last) begin
               upc_in = cond_true ? word.tgt_t : word.tgt_f;
            end
         end
         default: upc_in = UPC_PV0;
      endcase
   end

   // outputs
   always_comb begin
      ctrl          = '0;
      ctrl.addr_sel = word.addr_sel;
      ctrl.cond     = word.cond;
      ctrl.cmp_sel  = word.cmp_sel;
      ctrl.act_t    = word.act_t;
      ctrl.act_f    = word.act_f;
      case (state_ff)
         SEQ_IDLE: begin
            ctrl.start = search_go;
         end
         SEQ_RUN: begin
            ctrl.busy    = 1'b1;
            ctrl.step_en = !word.last;
            ctrl.finish  = word.last && rsp_free;
         end
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         upc_ff   <= UPC_PV0;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
      end
   end

endmodule

// ----- hdl/rssa_dpath.sv -----
// rssa_dpath: search datapath with bounds, pivot, key and result registers
// driven by the control word; depends on rssa_pkg
module rssa_dpath
   import rssa_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  seq_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]  used_count,
   input  logic [DATA_W-1:0] key,
   input  logic [DATA_W-1:0] rd_data,
   output logic              cond_true,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   output logic              res_found,
   output logic [IDX_W-1:0]  res_index
);

   localparam int SW = AW + 2;
   localparam logic signed [SW-1:0] ONE_S = SW'(1);

   logic signed [SW-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [SW-1:0]     piv_ff, piv_in, idx_ff, idx_in;
   logic signed [DATA_W-1:0] em_ff, em_in, key_ff, key_in;
   logic                     hit_ff, hit_in;

   logic [31:0]              count_clip;
   logic signed [SW-1:0]     n_cnt, n_last;
   logic signed [SW:0]       mid_sum;
   logic signed [SW-1:0]     mid_calc, mid_p1, mid_m1, piv_p1, piv_m1;
   logic signed [DATA_W-1:0] rdata_s;
   act_type                  act;

   // element count limited to the store depth
   assign count_clip = (32'(used_count) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(used_count);
   assign n_cnt      = SW'(count_clip);
   assign n_last     = n_cnt - ONE_S;

   assign mid_sum  = {lo_ff[SW-1], lo_ff} + {hi_ff[SW-1], hi_ff};
   assign mid_calc = mid_sum[SW:1];
   assign mid_p1   = mid_ff + ONE_S;
   assign mid_m1   = mid_ff - ONE_S;
   assign piv_p1   = piv_ff + ONE_S;
   assign piv_m1   = piv_ff - ONE_S;
   assign rdata_s  = $signed(rd_data);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:        cond_true = 1'b0;
         COND_HI_LT_LO:     cond_true = hi_ff < lo_ff;
         COND_HI_EQ_LO:     cond_true = hi_ff == lo_ff;
         COND_SUCC_DROP:    cond_true = (mid_ff < hi_ff) && (em_ff > rdata_s);
         COND_PRED_RISE:    cond_true = (mid_ff > lo_ff) && (em_ff < rdata_s);
         COND_FIRST_GE_MID: cond_true = rdata_s >= em_ff;
         COND_KEY_EQ:       cond_true = rdata_s == key_ff;
         COND_KEY_LE_OR_GT: begin
            if (ctrl.cmp_sel == CMP_FIRST_LE_KEY) begin
               cond_true = rdata_s <= key_ff;
            end else begin
               cond_true = key_ff > rdata_s;
            end
         end
         default:           cond_true = 1'b0;
      endcase
   end

   // read port address
   always_comb begin
      rd_en = ctrl.step_en && (ctrl.addr_sel != ADDR_NONE);
      case (ctrl.addr_sel)
         ADDR_MID_CALC: rd_addr = mid_calc[AW-1:0];
         ADDR_MID_P1:   rd_addr = mid_p1[AW-1:0];
         ADDR_MID_M1:   rd_addr = mid_m1[AW-1:0];
         ADDR_LO:       rd_addr = lo_ff[AW-1:0];
         ADDR_PIV:      rd_addr = piv_ff[AW-1:0];
         ADDR_ZERO:     rd_addr = '0;
         default:       rd_addr = '0;
      endcase
   end

   assign act = cond_true ? ctrl.act_t : ctrl.act_f;

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mid_in = mid_ff;
      piv_in = piv_ff;
      idx_in = idx_ff;
      em_in  = em_ff;
      key_in = key_ff;
      hit_in = hit_ff;
      if (ctrl.start) begin
         key_in = $signed(key);
         lo_in  = '0;
         hi_in  = n_last;
      end else if (ctrl.step_en) begin
         case (act)
            ACT_NONE:        ;
            ACT_SET_MID:     mid_in = mid_calc;
            ACT_LATCH_EM:    em_in = rdata_s;
            ACT_PIV_MID:     piv_in = mid_ff;
            ACT_PIV_MID_M1:  piv_in = mid_m1;
            ACT_PIV_LO:      piv_in = lo_ff;
            ACT_HI_MID_M1:   hi_in = mid_m1;
            ACT_LO_MID_P1:   lo_in = mid_p1;
            ACT_RANGE_FULL: begin
               lo_in = '0;
               hi_in = n_last;
            end
            ACT_RANGE_LEFT: begin
               lo_in = '0;
               hi_in = piv_m1;
            end
            ACT_RANGE_RIGHT: begin
               lo_in = piv_p1;
               hi_in = n_last;
            end
            ACT_FOUND_PIV: begin
               hit_in = 1'b1;
               idx_in = piv_ff;
            end
            ACT_FOUND_MID: begin
               hit_in = 1'b1;
               idx_in = mid_ff;
            end
            ACT_MISS: begin
               hit_in = 1'b0;
               idx_in = '0;
            end
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      piv_ff <= piv_in;
      idx_ff <= idx_in;
      em_ff  <= em_in;
      key_ff <= key_in;
      hit_ff <= hit_in;
   end

   assign res_found = hit_ff;
   assign res_index = IDX_W'(idx_ff);

endmodule

// ----- hdl/rotated_sorted_array_search_unit.sv -----
// rotated_sorted_array_search_unit: write items are stored when taken; a search
// runs the microprogram: pivot bisection rounds (log2 n + 1 rounds at most),
// the pivot check, binary search rounds, then the result is posted; one search
// at a time
// reset: synchronous, active high; clears used_count, sequencer and response valid
// depends on rssa_pkg, rssa_ram, rssa_useq, rssa_dpath
module rotated_sorted_array_search_unit
   import rssa_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [POS_W-1:0]  req_position,
   input  logic [DATA_W-1:0] req_value,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [IDX_W-1:0]  rsp_found_index,
   // configuration write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_used_count
);

   localparam int AW = $clog2(DEPTH);

   // configuration register
   logic [CNT_W-1:0]  used_count_ff, used_count_in;

   // response output register, parts the sequencer from the consumer
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]  rsp_found_index_ff, rsp_found_index_in;

   logic              req_take, search_go, rsp_free;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   logic              cond_true;
   logic              res_found;
   logic [IDX_W-1:0]  res_index;
   seq_ctrl_type      ctrl;

   // requests are taken only while no search is in flight
   assign req_stall = ctrl.busy;
   assign req_take  = req_valid && !req_stall;
   assign search_go = req_take && (req_op == OP_SEARCH);

   // writes beyond the store are dropped
   assign ram_wr_en   = req_take && (req_op == OP_WRITE) &&
                        (32'(req_position) < 32'(DEPTH));
   assign ram_wr_addr = AW'(req_position);

   // result slot can take a new transaction this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign csr_ready     = 1'b1;
   assign used_count_in = (csr_valid && csr_ready) ? csr_used_count : used_count_ff;

   rssa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rssa_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .search_go (search_go),
      .cond_true (cond_true),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl)
   );

   rssa_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .ctrl       (ctrl),
      .used_count (used_count_ff),
      .key        (req_value),
      .rd_data    (ram_rd_data),
      .cond_true  (cond_true),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .res_found  (res_found),
      .res_index  (res_index)
   );

   // load a finished search, drop the transaction once taken
   always_comb begin
      rsp_valid_in       = rsp_valid_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_found_index_in = rsp_found_index_ff;
      if (ctrl.finish) begin
         rsp_valid_in       = 1'b1;
         rsp_found_in       = res_found;
         rsp_found_index_in = res_index;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff       <= rsp_found_in;
      rsp_found_index_ff <= rsp_found_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_found_index_ff;

   // a result is posted only into a free slot
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> rsp_free)
      else $error("result posted over a pending transaction");

   // the store is never written while a search reads it
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !ctrl.busy)
      else $error("store write during a search");

   // an accepted search starts the sequencer
   a_search_runs: assert property (@(posedge clock) disable iff (reset)
      search_go |=> ctrl.busy)
      else $error("search accepted but sequencer idle");

   // a miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_index == '0))
      else $error("miss with nonzero index");

endmodule

// ----- verif/testbench.sv -----
// testbench for rotated_sorted_array_search_unit: element writes and key searches
// over rotated ascending runs, checked against an in-bench pivot and bisection predictor
// depends on rssa_pkg and the unit's rtl under hdl
module testbench;
   import rssa_pkg::*;

   localparam int DEPTH = 1024;
   localparam int RANDOM_ITEMS = 1350;
   localparam int SETTLE_CYCLES = 12;
   localparam int TAIL_CYCLES = 120;     // longer than one full-depth search
   localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [CNT_W-1:0] COUNT_ALL_ONES = 11'h7ff;

   typedef struct packed {
      logic              op;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] slot;
   } match_type;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_COMB,
      STALL_HEAVY
   } stall_mode_type;

   // every input known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_WRITE;
   logic [POS_W-1:0]  req_position = '0;
   logic [DATA_W-1:0] req_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [IDX_W-1:0]  rsp_found_index;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_used_count = '0;

   // predictor state: a copy of the element store and the active search span
   int shadow_store [DEPTH];
   int span_count = 0;
   // image of the run loaded by the current phase, used to pick keys
   int run_img [DEPTH];

   req_item_type req_backlog [$];
   match_type    expected_matches [$];
   int items_queued = 0;
   int items_accepted = 0;
   int errors = 0;

   // driver and monitor bookkeeping
   int             burst_left;
   int             gap_left;
   req_item_type   next_req;
   match_type      want;
   int             stall_phase;
   stall_mode_type stall_mode;

   rotated_sorted_array_search_unit #(
      .DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_used_count  (csr_used_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // bisection for the rotation point; -1 when the span is empty or has none
   function automatic int locate_pivot(input int lo_in, input int hi_in);
      int lo, hi, mid;
      lo = lo_in;
      hi = hi_in;
      while (hi >= lo) begin
         if (hi == lo)
            return lo;
         mid = (lo + hi) / 2;
         if (mid < hi && shadow_store[mid] > shadow_store[mid + 1])
            return mid;
         if (mid > lo && shadow_store[mid] < shadow_store[mid - 1])
            return mid - 1;
         if (shadow_store[lo] >= shadow_store[mid])
            hi = mid - 1;
         else
            lo = mid + 1;
      end
      return -1;
   endfunction

   // plain binary search over [lo, hi]; -1 when the key is absent
   function automatic int range_search(input int lo_in, input int hi_in, input int key);
      int lo, hi, mid;
      lo = lo_in;
      hi = hi_in;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key == shadow_store[mid])
            return mid;
         if (key > shadow_store[mid])
            lo = mid + 1;
         else
            hi = mid - 1;
      end
      return -1;
   endfunction

   function automatic match_type predict_lookup(input int key);
      int        n, piv, hit;
      match_type m;
      n = span_count;
      piv = locate_pivot(0, n - 1);
      if (piv < 0)
         hit = range_search(0, n - 1, key);
      else if (shadow_store[piv] == key)
         hit = piv;
      else if (shadow_store[0] <= key)
         hit = range_search(0, piv - 1, key);
      else
         hit = range_search(piv + 1, n - 1, key);
      m.found = (hit >= 0);
      m.slot = (hit >= 0) ? IDX_W'(hit) : '0;
      return m;
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: bursts of transactions with random gaps in between
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 4;
         gap_left = 0;
      end else begin
         // a transaction completes here: update the predictor in arrival order
         if (req_valid && !req_stall) begin
            if (req_op == OP_WRITE)
               shadow_store[req_position] = int'(req_value);
            else
               expected_matches.push_back(predict_lookup(int'(req_value)));
            items_accepted++;
         end
         // payload only moves once the previous transaction is gone
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || req_backlog.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_req = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_op <= next_req.op;
               req_position <= next_req.position;
               req_value <= next_req.value;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(16, 1);
                  // about a third of the bursts run straight into the next one
                  gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(7, 1);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor and stall pattern
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: response with no search outstanding, found %0b index %0d",
                        $time, rsp_found, rsp_found_index);
               errors++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b, actual %0b",
                           $time, want.found, rsp_found);
                  errors++;
               end
               if (rsp_found_index !== want.slot) begin
                  $display("%0t: found_index mismatch, expected %0d, actual %0d",
                           $time, want.slot, rsp_found_index);
                  errors++;
               end
            end
         end
         // stall mode rotates through four patterns, one of them stall free
         stall_phase++;
         stall_mode = stall_mode_type'((stall_phase / 300) % 4);
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_COIN:  rsp_stall <= ($urandom_range(1, 0) == 0);
            STALL_COMB:  rsp_stall <= ((stall_phase % 7) < 3);
            default:     rsp_stall <= ($urandom_range(3, 0) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_item(input logic op, input logic [POS_W-1:0] position,
                            input logic [DATA_W-1:0] value);
      req_item_type it;
      it.op = op;
      it.position = position;
      it.value = value;
      req_backlog.push_back(it);
      items_queued++;
   endtask

   // hold the sender until every transaction is in and every answer is out
   task automatic drain_block();
      while (items_accepted != items_queued || expected_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only issued while the unit is idle
   task automatic program_used_count(input logic [CNT_W-1:0] count);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_used_count <= count;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      span_count = (count > DEPTH) ? DEPTH : int'(count);
   endtask

   // write positions 0..n-1 with a rotated run: strictly ascending, ascending
   // with repeats, or plain noise
   task automatic load_run(input int n);
      int     ascending [DEPTH];
      int     kind, rot, i;
      longint start, room, stepmax, acc;
      if (n == 0)
         return;
      kind = $urandom_range(19, 0);
      if (kind < 12) begin
         start = longint'(int'($urandom));
         room = 64'sd2147483647 - start;
         if (room < n) begin
            start = -64'sd2147483648;
            room = 64'sd4294967295;
         end
         stepmax = room / n;
         // dense runs half of the time so that neighbours of keys are present
         if ($urandom_range(1, 0) == 0 && stepmax > 4)
            stepmax = 4;
         acc = start;
         for (i = 0; i < n; i++) begin
            ascending[i] = int'(acc);
            acc = acc + longint'($urandom_range(32'(stepmax), 1));
         end
      end else if (kind < 17) begin
         // repeated values
         acc = longint'($urandom_range(6, 0)) - 3;
         for (i = 0; i < n; i++) begin
            ascending[i] = int'(acc);
            acc = acc + longint'($urandom_range(1, 0));
         end
      end else begin
         for (i = 0; i < n; i++)
            ascending[i] = int'($urandom);
      end
      rot = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(n - 1, 0);
      for (i = 0; i < n; i++) begin
         run_img[i] = ascending[(i + rot) % n];
         push_item(OP_WRITE, POS_W'(i), run_img[i]);
      end
   endtask

   // mostly keys from the run, some neighbours, extremes and noise
   function automatic logic [DATA_W-1:0] pick_key(input int n);
      int roll;
      roll = $urandom_range(19, 0);
      if (n == 0 || roll >= 17)
         return $urandom;
      if (roll < 12)
         return run_img[$urandom_range(n - 1, 0)];
      if (roll < 14)
         return run_img[$urandom_range(n - 1, 0)] + 1;
      if (roll == 14)
         return run_img[$urandom_range(n - 1, 0)] - 1;
      if (roll == 15)
         return VAL_MIN;
      return VAL_MAX;
   endfunction

   // searches over the current span, with stray writes and an optional pause
   task automatic run_searches(input int n, input int count, input bit pause_mid);
      int k;
      for (k = 0; k < count; k++) begin
         if (n > 0 && $urandom_range(9, 0) == 0)
            push_item(OP_WRITE, POS_W'($urandom_range(n - 1, 0)), $urandom);
         if (pause_mid && k == count / 2)
            drain_block();
         push_item(OP_SEARCH, POS_W'($urandom), pick_key(n));
      end
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int n, random_floor;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty store: used_count is still zero from reset
      push_item(OP_SEARCH, '0, VAL_MAX);
      push_item(OP_SEARCH, '1, VAL_MIN);
      // top position
      push_item(OP_WRITE, '1, 32'hffff_ffff);
      // unrotated run of three: the bisection lands on the last element
      push_item(OP_WRITE, 10'd0, 32'd10);
      push_item(OP_WRITE, 10'd1, 32'd20);
      push_item(OP_WRITE, 10'd2, 32'd30);
      drain_block();
      program_used_count(11'd3);
      push_item(OP_SEARCH, 10'd0, 32'd10);
      push_item(OP_SEARCH, 10'd0, 32'd20);
      push_item(OP_SEARCH, 10'd0, 32'd30);
      push_item(OP_SEARCH, 10'd0, 32'd25);
      push_item(OP_SEARCH, 10'd0, 32'd5);
      // rotated run holding both value extremes
      push_item(OP_WRITE, 10'd0, 32'd0);
      push_item(OP_WRITE, 10'd1, VAL_MAX);
      push_item(OP_WRITE, 10'd2, VAL_MIN);
      push_item(OP_WRITE, 10'd3, -32'sd5);
      push_item(OP_WRITE, 10'd4, 32'hffff_ffff);
      drain_block();
      program_used_count(11'd5);
      push_item(OP_SEARCH, 10'd0, VAL_MIN);
      push_item(OP_SEARCH, 10'd0, VAL_MAX);
      push_item(OP_SEARCH, 10'd0, 32'd0);
      push_item(OP_SEARCH, 10'd0, 32'hffff_ffff);
      push_item(OP_SEARCH, 10'd0, 32'd7);

      random_floor = items_queued;

      // full store, then counts at and above the store depth
      load_run(DEPTH);
      drain_block();
      program_used_count(CNT_W'(DEPTH));
      run_searches(DEPTH, 14, 1'b1);
      drain_block();
      program_used_count(COUNT_ALL_ONES);
      run_searches(DEPTH, 10, 1'b0);
      drain_block();
      program_used_count(11'd1025);
      run_searches(DEPTH, 8, 1'b0);

      // small runs until the random budget is spent
      while (items_queued < random_floor + RANDOM_ITEMS) begin
         case ($urandom_range(9, 0))
            0:       n = 0;
            1:       n = 1;
            2:       n = 2;
            default: n = $urandom_range(32, 3);
         endcase
         load_run(n);
         drain_block();
         program_used_count(CNT_W'(n));
         run_searches(n, $urandom_range(10, 4), ($urandom_range(3, 0) == 0));
      end

      // back to an empty span for the last few searches
      drain_block();
      program_used_count('0);
      run_searches(0, 4, 1'b0);

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_matches.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // watchdog, well above the slowest legal run
   initial begin
      #15_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
